>>> src/assert_macros.svh
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/dpd_pkg.sv
`default_nettype none

package dpd_pkg;

   // Fixed field widths of the stream word and the result.
   localparam int WORD_W = 18;
   localparam int POS_W  = 18;

   // Defaults for the top level parameters.
   localparam int WORD_BITS_DEFAULT = 18;
   localparam int NAME_MAX_DEFAULT  = 32;

   // Last timestamp word index within a package.
   localparam logic [POS_W-1:0] TS_LAST = POS_W'(3);

   // Position in the package frame.
   typedef enum logic [2:0] {
      PH_SIZE       = 3'd0,
      PH_SOURCE     = 3'd1,
      PH_NAME_FIRST = 3'd2,
      PH_NAME_REST  = 3'd3,
      PH_TYPE       = 3'd4,
      PH_TS         = 3'd5,
      PH_PAYLOAD    = 3'd6
   } phase_type;

   // Classification of one word.
   typedef enum logic [2:0] {
      K_SIZE    = 3'd0,
      K_SOURCE  = 3'd1,
      K_NCHAR   = 3'd2,
      K_NREUSE  = 3'd3,
      K_NEND    = 3'd4,
      K_TYPE    = 3'd5,
      K_TS      = 3'd6,
      K_PAYLOAD = 3'd7
   } kind_type;

   // One result item.
   typedef struct packed {
      kind_type          kind;
      logic [WORD_W-1:0] value;
      logic [POS_W-1:0]  position;
      logic              name_overflow;
      logic              package_end;
   } result_type;

endpackage

`default_nettype wire

>>> src/dpd_fsm.sv
`default_nettype none

module dpd_fsm
   import dpd_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT,
   parameter int NAME_MAX  = NAME_MAX_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [WORD_W-1:0] word,
   output result_type             result
);

   // Only the low WORD_BITS bits of a word are meaningful.
   localparam int USED_BITS = (WORD_BITS < WORD_W) ? WORD_BITS : WORD_W;
   localparam logic [WORD_W-1:0] WORD_MASK = {WORD_W{1'b1}} >> (WORD_W - USED_BITS);
   localparam logic [POS_W-1:0] NAME_LIMIT = POS_W'(NAME_MAX);
   localparam logic FIRST_OVF = (NAME_MAX <= 0);

   phase_type         phase_ff, phase_in;
   logic [WORD_W-1:0] payload_left_ff, payload_left_in;
   logic [POS_W-1:0]  field_index_ff, field_index_in;

   logic [WORD_W-1:0] w;
   logic [7:0]        ch;
   logic [POS_W-1:0]  index_bump;
   logic [WORD_W-1:0] left_dec;

   // Frame state advances only when a word is classified.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SIZE;
         payload_left_ff <= '0;
         field_index_ff  <= '0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         payload_left_ff <= payload_left_in;
         field_index_ff  <= field_index_in;
      end
   end

   assign w  = word & WORD_MASK;
   assign ch = w[7:0];

   // Index counters saturate instead of wrapping.
   assign index_bump = (field_index_ff == {POS_W{1'b1}}) ? field_index_ff
                                                        : field_index_ff + POS_W'(1);
   assign left_dec = (payload_left_ff != '0) ? payload_left_ff - WORD_W'(1) : '0;

   // Classify the word and compute the next frame state.
   always_comb begin
      phase_in              = phase_ff;
      payload_left_in       = payload_left_ff;
      field_index_in        = field_index_ff;
      result.kind           = K_SIZE;
      result.value          = w;
      result.position       = '0;
      result.name_overflow  = 1'b0;
      result.package_end    = 1'b0;
      case (phase_ff)
         PH_SOURCE: begin
            result.kind = K_SOURCE;
            phase_in    = PH_NAME_FIRST;
         end
         PH_NAME_FIRST: begin
            result.value = WORD_W'(ch);
            if (ch == 8'd0) begin
               // A leading zero reuses the previous name.
               result.kind = K_NREUSE;
               phase_in    = PH_TYPE;
            end else begin
               result.kind          = K_NCHAR;
               result.name_overflow = FIRST_OVF;
               field_index_in       = POS_W'(1);
               phase_in             = PH_NAME_REST;
            end
         end
         PH_NAME_REST: begin
            result.value         = WORD_W'(ch);
            result.position      = field_index_ff;
            result.name_overflow = (field_index_ff >= NAME_LIMIT);
            if (ch == 8'd0) begin
               result.kind = K_NEND;
               phase_in    = PH_TYPE;
            end else begin
               result.kind    = K_NCHAR;
               field_index_in = index_bump;
            end
         end
         PH_TYPE: begin
            result.kind    = K_TYPE;
            field_index_in = '0;
            phase_in       = PH_TS;
         end
         PH_TS: begin
            result.kind     = K_TS;
            result.position = field_index_ff;
            if (field_index_ff >= TS_LAST) begin
               field_index_in = '0;
               if (payload_left_ff == '0) begin
                  // Empty payload ends the package on the last timestamp.
                  result.package_end = 1'b1;
                  phase_in           = PH_SIZE;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               field_index_in = field_index_ff + POS_W'(1);
            end
         end
         PH_PAYLOAD: begin
            result.kind     = K_PAYLOAD;
            result.position = field_index_ff;
            field_index_in  = index_bump;
            payload_left_in = left_dec;
            if (left_dec == '0) begin
               result.package_end = 1'b1;
               phase_in           = PH_SIZE;
            end
         end
         default: begin
            // Size word, also taken for the unused phase code.
            result.kind     = K_SIZE;
            payload_left_in = w;
            field_index_in  = '0;
            phase_in        = PH_SOURCE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/data_package_deframer.sv
// An accepted word is held in the input register, then classified into the result register.
// Throughput: one word per cycle while rsp_stall is low; the input register and
// the result register each take a new transfer whenever the stage after them moves.
// Reset: synchronous, active high; clears both valid flags and returns the
// frame state to expecting a size word with zero counters.
`default_nettype none

module data_package_deframer
   import dpd_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT,
   parameter int NAME_MAX  = NAME_MAX_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [WORD_W-1:0] req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_kind,
   output logic [WORD_W-1:0]      rsp_value,
   output logic [POS_W-1:0]       rsp_position,
   output logic                   rsp_name_overflow,
   output logic                   rsp_package_end
);

   logic              in_valid_ff, in_valid_in;
   logic [WORD_W-1:0] word_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        result_ff;
   result_type        result;
   logic              out_move;
   logic              fire;
   logic              req_take;

   // The result register moves when empty or when its transfer completes.
   assign out_move  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_move;
   assign req_stall = in_valid_ff && !out_move;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_stall ? 1'b1 : req_valid;
   assign rsp_valid_in = out_move ? in_valid_ff : rsp_valid_ff;

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         word_ff <= req_word;
      end
      if (fire) begin
         result_ff <= result;
      end
   end

   dpd_fsm #(
      .WORD_BITS (WORD_BITS),
      .NAME_MAX  (NAME_MAX)
   ) u_fsm (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .word   (word_ff),
      .result (result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = result_ff.kind;
   assign rsp_value         = result_ff.value;
   assign rsp_position      = result_ff.position;
   assign rsp_name_overflow = result_ff.name_overflow;
   assign rsp_package_end   = result_ff.package_end;

endmodule

`default_nettype wire

>>> src/dpd_checker.sv
`default_nettype none
`include "assert_macros.svh"

module dpd_checker
   import dpd_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [2:0]        rsp_kind,
   input wire logic [POS_W-1:0]  rsp_position,
   input wire logic              rsp_name_overflow,
   input wire logic              rsp_package_end
);

   // A stalled result stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A package ends only on a timestamp or payload word.
   `ASSERT_IMPLY(a_end_kind, clock, reset, rsp_valid && rsp_package_end,
      rsp_kind == K_TS || rsp_kind == K_PAYLOAD)

   // Overflow is only flagged on name characters and the name terminator.
   `ASSERT_IMPLY(a_ovf_kind, clock, reset, rsp_valid && rsp_name_overflow,
      rsp_kind == K_NCHAR || rsp_kind == K_NEND)

   // Timestamp positions stay within the four timestamp words.
   `ASSERT_IMPLY(a_ts_pos, clock, reset, rsp_valid && rsp_kind == K_TS,
      rsp_position <= TS_LAST)

   // Header words carry no position.
   `ASSERT_IMPLY(a_hdr_pos, clock, reset,
      rsp_valid && (rsp_kind == K_SIZE || rsp_kind == K_SOURCE ||
      rsp_kind == K_NREUSE || rsp_kind == K_TYPE), rsp_position == '0)

endmodule

bind data_package_deframer dpd_checker u_dpd_checker (.*);

`default_nettype wire
